/* rtl/assert_macros.svh */
// Assertion macros for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/jts_pkg.sv */
// Shared types, codes and keyword tables for the JSON token scanner.
`timescale 1ns / 1ps
package jts_pkg;

  localparam int JTS_FIFO_DEPTH = 4;

  // token kinds
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COLON  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_TRUE   = 4'd8;
  localparam logic [3:0] KIND_EOF    = 4'd11;
  localparam logic [3:0] KIND_ERROR  = 4'd12;

  // keyword selector
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_STRING  = 5'b00010,
    MODE_NUMBER  = 5'b00100,
    MODE_KEYWORD = 5'b01000,
    MODE_ERROR   = 5'b10000
  } jts_mode_t;

  typedef struct packed {
    logic       last;
    logic       token_done;
    logic       has_content;
    logic [7:0] content_byte;
    logic [3:0] token_kind;
  } jts_res_t;

  function automatic logic [7:0] kw_char(input logic [1:0] c, input logic [2:0] p);
    logic [7:0] ch;
    ch = 8'h00;
    case (c)
      KW_TRUE: begin
        case (p)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (p)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (p)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] c);
    logic [2:0] len;
    case (c)
      KW_TRUE:  len = 3'd4;
      KW_FALSE: len = 3'd5;
      KW_NULL:  len = 3'd4;
      default:  len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic jts_res_t mk_res(input logic [3:0] kind, input logic [7:0] b,
                                      input logic has, input logic done);
    jts_res_t r;
    r.last         = 1'b0;
    r.token_done   = done;
    r.has_content  = has;
    r.content_byte = has ? b : 8'h00;
    r.token_kind   = kind;
    return r;
  endfunction

endpackage

/* rtl/json_token_scanner.sv */
// A result is written into the result queue by the byte transfer that causes it, and is offered from there.
// Throughput: one byte per cycle while in_tready is high; a byte ending a number, or end of input
// in a string or number, may give two results, drained from the result queue one per cycle while out_tready is high.
// in_tready is high while the result queue has room for two more results.
// Reset (rst_n low, synchronous) returns the scanner to idle and empties the queue.
// Top level: JSON token scanner.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module json_token_scanner import jts_pkg::*; #(
  parameter int FIFO_DEPTH = JTS_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_in
  input  logic       in_tlast,   // end_of_input
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] content_byte
  output logic [5:0] out_tuser,  // [3:0] token_kind, [4] has_content, [5] token_done
  output logic       out_tlast   // last result of this input transfer
);

  logic       step;
  logic       room2;
  logic [1:0] res_cnt;
  jts_res_t   res0, res1, head;
  jts_mode_t  mode;

  assign in_tready = room2;
  assign step      = in_tvalid && in_tready;

  jts_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .byte_in (in_tdata),
    .eoi     (in_tlast),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1),
    .mode    (mode)
  );

  jts_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (step ? res_cnt : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (head)
  );

  assign out_tdata = head.content_byte;
  assign out_tuser = {head.token_done, head.has_content, head.token_kind};
  assign out_tlast = head.last;

  `ASSERT_PROP(a_mode_onehot, clk, rst_n, $onehot(mode))
  `ASSERT_PROP(a_eoi_to_idle, clk, rst_n, (step && in_tlast) |=> (mode == MODE_IDLE))
  `ASSERT_PROP(a_pair_closes, clk, rst_n, (step && res_cnt == 2'd2) |-> (res0.token_done && !res0.has_content && !res0.last))
  `ASSERT_NEVER(a_content_kind, clk, rst_n, out_tvalid && out_tuser[4] && (out_tuser[5] || (out_tuser[3:0] != KIND_STRING && out_tuser[3:0] != KIND_NUMBER)))

endmodule

/* rtl/jts_scan.sv */
// Scanner state and per-byte token decode; yields up to two results per transfer.
`timescale 1ns / 1ps
module jts_scan import jts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic [7:0] byte_in,
  input  logic      eoi,
  output logic [1:0] res_cnt,
  output jts_res_t  res0,
  output jts_res_t  res1,
  output jts_mode_t mode
);

  jts_mode_t  mode_r, mode_nxt;
  logic [1:0] kw_choice_r, kw_choice_nxt;
  logic [2:0] kw_pos_r, kw_pos_nxt;

  // idle-mode decode of the current byte
  logic       idl_emit;
  jts_res_t   idl_res;
  jts_mode_t  idl_mode;
  logic [1:0] idl_choice;
  logic [2:0] idl_pos;
  logic       is_space, is_digit;

  assign is_space = (byte_in == CH_SPACE) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);

  always_comb begin
    idl_emit   = 1'b0;
    idl_res    = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b1);
    idl_mode   = MODE_IDLE;
    idl_choice = kw_choice_r;
    idl_pos    = kw_pos_r;
    if (!is_space) begin
      case (byte_in)
        CH_LBRACE: begin idl_emit = 1'b1; idl_res = mk_res(KIND_LBRACE, 8'h00, 1'b0, 1'b1); end
        CH_RBRACE: begin idl_emit = 1'b1; idl_res = mk_res(KIND_RBRACE, 8'h00, 1'b0, 1'b1); end
        CH_LBRACK: begin idl_emit = 1'b1; idl_res = mk_res(KIND_LBRACK, 8'h00, 1'b0, 1'b1); end
        CH_RBRACK: begin idl_emit = 1'b1; idl_res = mk_res(KIND_RBRACK, 8'h00, 1'b0, 1'b1); end
        CH_COLON:  begin idl_emit = 1'b1; idl_res = mk_res(KIND_COLON, 8'h00, 1'b0, 1'b1); end
        CH_COMMA:  begin idl_emit = 1'b1; idl_res = mk_res(KIND_COMMA, 8'h00, 1'b0, 1'b1); end
        CH_QUOTE:  idl_mode = MODE_STRING;
        CH_T, CH_F, CH_N: begin
          idl_mode   = MODE_KEYWORD;
          idl_pos    = 3'd1;
          idl_choice = (byte_in == CH_T) ? KW_TRUE : (byte_in == CH_F) ? KW_FALSE : KW_NULL;
        end
        default: begin
          idl_emit = 1'b1;
          if (is_digit || byte_in == CH_MINUS) begin
            idl_mode = MODE_NUMBER;
            idl_res  = mk_res(KIND_NUMBER, byte_in, 1'b1, 1'b0);
          end else begin
            idl_mode = MODE_ERROR;
          end
        end
      endcase
    end
  end

  jts_res_t r0, r1;
  logic [1:0] cnt;
  logic [7:0] kw_exp;
  logic [2:0] kw_l;

  assign kw_exp = kw_char(kw_choice_r, kw_pos_r);
  assign kw_l   = kw_len(kw_choice_r);

  always_comb begin
    mode_nxt      = mode_r;
    kw_choice_nxt = kw_choice_r;
    kw_pos_nxt    = kw_pos_r;
    cnt           = 2'd0;
    r0            = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
    r1            = mk_res(KIND_EOF, 8'h00, 1'b0, 1'b1);
    if (eoi) begin
      mode_nxt      = MODE_IDLE;
      kw_choice_nxt = KW_TRUE;
      kw_pos_nxt    = 3'd0;
      case (mode_r)
        MODE_ERROR: cnt = 2'd0;
        MODE_KEYWORD: begin
          cnt = 2'd1;
          r0  = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b1);
        end
        MODE_STRING: begin
          cnt = 2'd2;
          r0  = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1);
        end
        MODE_NUMBER: begin
          cnt = 2'd2;
          r0  = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
        end
        default: cnt = 2'd1;
      endcase
    end else begin
      case (mode_r)
        MODE_ERROR: cnt = 2'd0;
        MODE_STRING: begin
          cnt = 2'd1;
          if (byte_in == CH_QUOTE) begin
            mode_nxt = MODE_IDLE;
            r0       = mk_res(KIND_STRING, 8'h00, 1'b0, 1'b1);
          end else begin
            r0 = mk_res(KIND_STRING, byte_in, 1'b1, 1'b0);
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
            cnt = 2'd1;
            r0  = mk_res(KIND_NUMBER, byte_in, 1'b1, 1'b0);
          end else begin
            // close the number, then treat the byte as if idle
            r0            = mk_res(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
            r1            = idl_res;
            cnt           = idl_emit ? 2'd2 : 2'd1;
            mode_nxt      = idl_mode;
            kw_choice_nxt = idl_choice;
            kw_pos_nxt    = idl_pos;
          end
        end
        MODE_KEYWORD: begin
          if (kw_choice_r == 2'd3 || kw_pos_r >= kw_l || kw_exp != byte_in) begin
            mode_nxt   = MODE_ERROR;
            kw_pos_nxt = 3'd0;
            cnt        = 2'd1;
            r0         = mk_res(KIND_ERROR, 8'h00, 1'b0, 1'b1);
          end else if (kw_pos_r + 3'd1 == kw_l) begin
            mode_nxt   = MODE_IDLE;
            kw_pos_nxt = 3'd0;
            cnt        = 2'd1;
            r0         = mk_res(KIND_TRUE + {2'b00, kw_choice_r}, 8'h00, 1'b0, 1'b1);
          end else begin
            kw_pos_nxt = kw_pos_r + 3'd1;
          end
        end
        default: begin
          r0            = idl_res;
          cnt           = idl_emit ? 2'd1 : 2'd0;
          mode_nxt      = idl_mode;
          kw_choice_nxt = idl_choice;
          kw_pos_nxt    = idl_pos;
        end
      endcase
    end
    if (cnt == 2'd1) r0.last = 1'b1;
    if (cnt == 2'd2) r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      kw_choice_r <= KW_TRUE;
      kw_pos_r    <= 3'd0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      kw_choice_r <= kw_choice_nxt;
      kw_pos_r    <= kw_pos_nxt;
    end
  end

  assign res_cnt = cnt;
  assign res0    = r0;
  assign res1    = r1;
  assign mode    = mode_r;

endmodule

/* rtl/jts_fifo.sv */
// Small result queue: takes up to two results per cycle, hands out one per cycle while pop_ready is high.
`timescale 1ns / 1ps
module jts_fifo import jts_pkg::*; #(
  parameter int DEPTH = JTS_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  jts_res_t   push0,
  input  jts_res_t   push1,
  output logic       room2,
  output logic       pop_valid,
  input  logic       pop_ready,
  output jts_res_t   pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jts_res_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CW-1:0] count_r, count_nxt;
  logic pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];
  assign room2     = (count_r <= CW'(DEPTH - 2));
  assign wr_ptr1   = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    case (push_cnt)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_cnt) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr_r] <= push0;
    if (push_cnt == 2'd2) mem[wr_ptr1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* verif/json_token_scanner_tb.sv */
// Testbench for the JSON token scanner: a directed document, then random documents, predicted token events.
`timescale 1ns / 1ps
module json_token_scanner_tb;
  import jts_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
  } scan_item_t;

  // expected token events and the scanner state behind them
  class token_scoreboard;
    jts_res_t  token_q[$];
    int        errors;
    jts_mode_t mode;
    logic [1:0] kw_sel;
    int        kw_pos;
    string     words[3];

    function new();
      words[0] = "true";
      words[1] = "false";
      words[2] = "null";
      errors = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode = MODE_IDLE;
      kw_sel = KW_TRUE;
      kw_pos = 0;
    endfunction

    function int pending();
      return token_q.size();
    endfunction

    function void add_token(logic [3:0] kind, logic [7:0] b, logic has, logic done);
      jts_res_t r;
      r.last = 1'b0;
      r.token_done = done;
      r.has_content = has;
      r.content_byte = has ? b : 8'h00;
      r.token_kind = kind;
      token_q.insert(token_q.size(), r);
    endfunction

    function void scan_fresh(logic [7:0] b);
      if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return;
      case (b)
        CH_LBRACE: add_token(KIND_LBRACE, 8'h00, 1'b0, 1'b1);
        CH_RBRACE: add_token(KIND_RBRACE, 8'h00, 1'b0, 1'b1);
        CH_LBRACK: add_token(KIND_LBRACK, 8'h00, 1'b0, 1'b1);
        CH_RBRACK: add_token(KIND_RBRACK, 8'h00, 1'b0, 1'b1);
        CH_COLON:  add_token(KIND_COLON, 8'h00, 1'b0, 1'b1);
        CH_COMMA:  add_token(KIND_COMMA, 8'h00, 1'b0, 1'b1);
        CH_QUOTE:  mode = MODE_STRING;
        CH_T, CH_F, CH_N: begin
          mode = MODE_KEYWORD;
          kw_sel = (b == CH_T) ? KW_TRUE : (b == CH_F) ? KW_FALSE : KW_NULL;
          kw_pos = 1;
        end
        default: begin
          if ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS) begin
            mode = MODE_NUMBER;
            add_token(KIND_NUMBER, b, 1'b1, 1'b0);
          end else begin
            mode = MODE_ERROR;
            add_token(KIND_ERROR, 8'h00, 1'b0, 1'b1);
          end
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic eoi);
      int n0;
      n0 = token_q.size();
      if (eoi) begin
        case (mode)
          MODE_ERROR: ;
          MODE_KEYWORD: add_token(KIND_ERROR, 8'h00, 1'b0, 1'b1);
          MODE_STRING: begin
            add_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
            add_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
          end
          MODE_NUMBER: begin
            add_token(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
            add_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
          end
          default: add_token(KIND_EOF, 8'h00, 1'b0, 1'b1);
        endcase
        clear_state();
      end else begin
        case (mode)
          MODE_ERROR: ;
          MODE_STRING: begin
            if (b == CH_QUOTE) begin
              mode = MODE_IDLE;
              add_token(KIND_STRING, 8'h00, 1'b0, 1'b1);
            end else begin
              add_token(KIND_STRING, b, 1'b1, 1'b0);
            end
          end
          MODE_NUMBER: begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
              add_token(KIND_NUMBER, b, 1'b1, 1'b0);
            end else begin
              // terminator closes the number, then is scanned on its own
              mode = MODE_IDLE;
              add_token(KIND_NUMBER, 8'h00, 1'b0, 1'b1);
              scan_fresh(b);
            end
          end
          MODE_KEYWORD: begin
            if (b != words[kw_sel][kw_pos]) begin
              mode = MODE_ERROR;
              kw_pos = 0;
              add_token(KIND_ERROR, 8'h00, 1'b0, 1'b1);
            end else if (kw_pos + 1 == words[kw_sel].len()) begin
              mode = MODE_IDLE;
              kw_pos = 0;
              add_token(KIND_TRUE + {2'b00, kw_sel}, 8'h00, 1'b0, 1'b1);
            end else begin
              kw_pos++;
            end
          end
          default: begin
            mode = MODE_IDLE;
            scan_fresh(b);
          end
        endcase
      end
      if (token_q.size() > n0) token_q[token_q.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int e, int a);
      if (e != a) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(logic [7:0] data, logic [5:0] user, logic lst);
      jts_res_t e;
      if (token_q.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual kind %0h data %0h",
                 $time, user[3:0], data);
        errors++;
        return;
      end
      e = token_q.pop_front();
      compare_field("token_kind", e.token_kind, user[3:0]);
      compare_field("content_byte", e.content_byte, data);
      compare_field("has_content", e.has_content, user[4]);
      compare_field("token_done", e.token_done, user[5]);
      compare_field("last", e.last, lst);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [5:0] out_tuser;
  logic       out_tlast;

  token_scoreboard sb = new();
  scan_item_t doc[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  json_token_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_input(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic void push_byte(logic [7:0] b);
    scan_item_t it;
    it.eoi = 1'b0;
    it.b = b;
    doc.insert(doc.size(), it);
  endfunction

  function automatic void push_eoi();
    scan_item_t it;
    it.eoi = 1'b1;
    it.b = 8'($urandom_range(0, 255));
    doc.insert(doc.size(), it);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endfunction

  function automatic void push_space();
    logic [7:0] ws[6];
    ws = '{CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR, CH_SPACE};
    if ($urandom_range(0, 2) == 0) push_byte(ws[$urandom_range(0, 5)]);
  endfunction

  function automatic void push_string();
    logic [7:0] b;
    int n;
    n = $urandom_range(0, 4);
    push_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_QUOTE) b = 8'h27;
      push_byte(b);
    end
    push_byte(CH_QUOTE);
  endfunction

  function automatic void gen_value(int depth);
    int pick;
    int n;
    pick = $urandom_range(0, (depth >= 3) ? 2 : 4);
    case (pick)
      0: push_string();
      1: begin
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) push_byte(CH_MINUS);
        for (int i = 0; i < n; i++) push_byte(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: push_text("true");
          1: push_text("false");
          default: push_text("null");
        endcase
      end
      3: begin
        n = $urandom_range(0, 3);
        push_byte(CH_LBRACK);
        for (int i = 0; i < n; i++) begin
          if (i > 0) push_byte(CH_COMMA);
          push_space();
          gen_value(depth + 1);
          push_space();
        end
        push_byte(CH_RBRACK);
      end
      default: begin
        n = $urandom_range(0, 3);
        push_byte(CH_LBRACE);
        for (int i = 0; i < n; i++) begin
          if (i > 0) push_byte(CH_COMMA);
          push_space();
          push_string();
          push_space();
          push_byte(CH_COLON);
          push_space();
          gen_value(depth + 1);
        end
        push_byte(CH_RBRACE);
      end
    endcase
  endfunction

  // mostly well-formed documents; some cut short, damaged or plain noise
  function automatic void gen_document();
    int style;
    int n;
    doc.delete();
    style = $urandom_range(0, 99);
    if (style < 5) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_space();
      gen_value(0);
      push_space();
      if (style < 20) begin
        n = $urandom_range(0, doc.size() - 1);
        while (doc.size() > n) void'(doc.pop_back());
      end else if (style < 30) begin
        doc[$urandom_range(0, doc.size() - 1)].b = 8'($urandom_range(0, 255));
      end
    end
    push_eoi();
  endfunction

  task automatic send_item(scan_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom_range(0, 255));
      in_tlast <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= it.b;
    in_tlast <= it.eoi;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_doc();
    foreach (doc[i]) send_item(doc[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct, int quota);
    int sent;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < quota) begin
      gen_document();
      send_doc();
      sent += doc.size();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    doc.delete();
    push_eoi();
    push_text("{[]}:,");
    push_byte(CH_QUOTE);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_QUOTE);
    push_text("\"\"");
    push_text("-,");
    push_text("null");
    push_text("7");
    push_byte(8'hFF);  // ends the number and is itself an error
    push_byte(8'h00);  // swallowed while in error
    push_eoi();
    push_text("\"x");
    push_eoi();
    push_text("fa");
    push_eoi();
    send_doc();

    run_phase(0, 0, 450);
    drain();
    run_phase(85, 0, 450);
    run_phase(0, 85, 450);
    run_phase(29, 29, 450);

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
